/* src/wuo_pkg.sv */
// Shared types and constants for the weight update optimiser.
// No dependencies.
package wuo_pkg;

  typedef enum logic [2:0] {
    MODE_SGD      = 3'd0,
    MODE_MOMENTUM = 3'd1,
    MODE_RMSPROP  = 3'd2,
    MODE_ADAGRAD  = 3'd3,
    MODE_ADAM     = 3'd4
  } mode_t;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_ALPHA  = 3'd1;
  localparam logic [2:0] REG_LAMBDA = 3'd2;
  localparam logic [2:0] REG_MU1    = 3'd3;
  localparam logic [2:0] REG_MU2    = 3'd4;
  localparam logic [2:0] REG_EPS    = 3'd5;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int CFG_BITS  = FRAC_BITS + 1;

endpackage

/* src/weight_update_optimizer.sv */
// Weight update optimiser top level: config registers and the update pipeline.
// Depends on wuo_pkg.
//
//  channel  | valid      | stall      | word
//  input    | in_valid   | in_stall   | grad, weight_in, moment_in, sq_accum_in, last_in
//  output   | out_valid  | out_stall  | weight_out, moment_out, sq_accum_out, last_out
//  config   | cfg_we     | -          | cfg_index, cfg_data
//
// One word per cycle while out_stall does not hold the pipeline; 91 register stages
// at the default sizes: four front stages (A to D), (WORD_BITS+FRAC_BITS+1)/2 root
// stages, WORD_BITS+FRAC_BITS+2 divide stages and the output register.
// Reset clears valid bits and restores register defaults.
// An output stall freezes the whole pipeline; in_stall follows out_stall when
// the last stage holds a word.
module weight_update_optimizer import wuo_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [WORD_BITS-1:0]   grad,
  input  logic signed [WORD_BITS-1:0]   weight_in,
  input  logic signed [WORD_BITS-1:0]   moment_in,
  input  logic [WORD_BITS-2:0]          sq_accum_in,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [WORD_BITS-1:0]   weight_out,
  output logic signed [WORD_BITS-1:0]   moment_out,
  output logic [WORD_BITS-2:0]          sq_accum_out,
  output logic                          last_out,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int XW = W + 2;
  localparam int RB = (W + F + 1) / 2 + 1;
  localparam int RS = (W + F + 1) / 2;
  localparam int DS = W + F + 2;
  localparam int DW = W + F + 2;
  localparam logic signed [XW-1:0] WMAX = XW'((65'sd1 <<< (W - 1)) - 1);
  localparam logic signed [XW-1:0] WMIN = -WMAX - XW'(1);
  localparam logic signed [XW-1:0] ONE  = XW'(65'sd1 <<< F);

  typedef logic signed [XW-1:0] wx_t;

  logic [2:0]          update_mode;
  logic [CFG_BITS-1:0] learn_rate, decay_coeff, first_decay, second_decay, epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_mode  <= 3'd0;
      learn_rate   <= CFG_BITS'(167772);
      decay_coeff  <= '0;
      first_decay  <= CFG_BITS'(15099494);
      second_decay <= CFG_BITS'(16760439);
      epsilon      <= CFG_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   update_mode  <= cfg_data[2:0];
        REG_ALPHA:  learn_rate   <= cfg_data;
        REG_LAMBDA: decay_coeff  <= cfg_data;
        REG_MU1:    first_decay  <= cfg_data;
        REG_MU2:    second_decay <= cfg_data;
        REG_EPS:    epsilon      <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic wx_t sat(input logic signed [2*XW+1:0] x);
    if (x > (2*XW+2)'(WMAX)) return WMAX;
    if (x < (2*XW+2)'(WMIN)) return WMIN;
    return XW'(x);
  endfunction

  function automatic wx_t sat_acc(input wx_t x);
    if (x < 0) return '0;
    return x;
  endfunction

  // truncating fixed-point product, saturated
  function automatic wx_t fmul(input wx_t a, input wx_t b);
    logic signed [2*XW-1:0] p;
    logic        [2*XW-1:0] m;
    logic                   n;
    p = (2*XW)'(a) * (2*XW)'(b);
    n = p[2*XW-1];
    m = n ? (2*XW)'(-p) : (2*XW)'(p);
    m = m >> F;
    if (m > (2*XW)'(WMAX)) return n ? WMIN : WMAX;
    return n ? XW'(-$signed(m)) : XW'($signed(m));
  endfunction

  // pipeline advance
  logic adv;
  localparam int NS = 4 + RS + DS + 1;
  logic [NS-1:0] vld;
  assign adv      = !(vld[NS-1] && out_stall);
  assign in_stall = !adv;

  // stage A: widen the inputs and register the config values
  typedef struct packed {
    logic [2:0] mode;
    wx_t g, w, m, v, alpha, mu1, mu2, eps, lam;
    logic last;
  } sa_t;
  sa_t s0;
  always_ff @(posedge clk) if (adv) begin
    s0.mode  <= update_mode;
    s0.g     <= XW'(grad);
    s0.w     <= XW'(weight_in);
    s0.m     <= XW'(moment_in);
    s0.v     <= XW'({1'b0, sq_accum_in});
    s0.alpha <= XW'(learn_rate);
    s0.lam   <= XW'(decay_coeff);
    s0.mu1   <= XW'(first_decay);
    s0.mu2   <= XW'(second_decay);
    s0.eps   <= XW'(epsilon);
    s0.last  <= last_in;
  end

  // stage B: first-level products
  typedef struct packed {
    sa_t  b;
    wx_t  wl, gg, vmu, mum, c2g, c1a;
  } sb_t;
  sb_t s2;
  always_ff @(posedge clk) if (adv) begin
    s2.b   <= s0;
    s2.wl  <= fmul(s0.w, s0.lam);
    s2.gg  <= fmul(s0.g, s0.g);
    s2.vmu <= fmul(s0.v, s0.mu2);
    s2.mum <= fmul(s0.mu1, s0.m);
    s2.c2g <= fmul(ONE - s0.mu2, s0.g);
    s2.c1a <= fmul(ONE - s0.mu1, s0.alpha);
  end

  // stage C: decayed gradient, second products
  typedef struct packed {
    sa_t b;
    wx_t gd, gg, vmu, mum, c2gg, c1a;
  } sc_t;
  sc_t s3;
  always_ff @(posedge clk) if (adv) begin
    s3.b    <= s2.b;
    s3.gd   <= sat((2*XW+2)'(s2.b.g) + (2*XW+2)'(s2.wl));
    s3.gg   <= s2.gg;
    s3.vmu  <= s2.vmu;
    s3.mum  <= s2.mum;
    s3.c2gg <= fmul(s2.c2g, s2.b.g);
    s3.c1a  <= s2.c1a;
  end

  // stage D: step products, new moments
  typedef struct packed {
    sa_t b;
    wx_t nm, nv, num, rin;
  } sd_t;
  sd_t s4;
  always_ff @(posedge clk) if (adv) begin
    wx_t ag, nm1, nm4, nm_n, nv_n, num_n, rin_n;
    ag  = fmul(s3.b.alpha, s3.gd);
    nm1 = sat((2*XW+2)'(s3.mum) - (2*XW+2)'(ag));
    nm4 = sat((2*XW+2)'(s3.mum) - (2*XW+2)'(fmul(s3.c1a, s3.gd)));
    nm_n  = s3.b.m;
    nv_n  = s3.b.v;
    num_n = ag;
    rin_n = '0;
    unique case (s3.b.mode)
      MODE_SGD:      num_n = ag;
      MODE_MOMENTUM: nm_n  = nm1;
      MODE_RMSPROP, MODE_ADAM: begin
        nv_n  = sat_acc(sat((2*XW+2)'(s3.vmu) + (2*XW+2)'(s3.c2gg)));
        rin_n = nv_n + s3.b.eps;
        if (s3.b.mode == MODE_ADAM) begin
          nm_n  = nm4;
          num_n = nm4;
        end
      end
      MODE_ADAGRAD: begin
        nv_n  = sat_acc(sat((2*XW+2)'(s3.b.v) + (2*XW+2)'(s3.gg)));
        rin_n = nv_n;
      end
      default: ;
    endcase
    s4.b   <= s3.b;
    s4.nm  <= nm_n;
    s4.nv  <= nv_n;
    s4.num <= num_n;
    s4.rin <= rin_n;
  end

  // root pipeline: one result bit per stage
  typedef struct packed {
    sd_t d;
    logic [2*RB+1:0] x;
    logic [2*RB+1:0] r;
    logic [RB-1:0]   q;
  } rt_t;
  rt_t rp [RS+1];
  always_comb begin
    rp[0].d = s4;
    rp[0].x = (2*RB+2)'({s4.rin[XW-2:0], F'(0)}) << (2*RB+2-2*RS);
    rp[0].r = '0;
    rp[0].q = '0;
  end
  for (genvar i = 0; i < RS; i++) begin : g_root
    rt_t st;
    always_ff @(posedge clk) if (adv) begin
      logic [2*RB+1:0] r, t;
      r = {rp[i].r[2*RB-1:0], rp[i].x[2*RB+1:2*RB]};
      t = (2*RB+2)'({rp[i].q, 2'b01});
      st.d <= rp[i].d;
      st.x <= rp[i].x << 2;
      if (r >= t) begin
        st.r <= r - t;
        st.q <= {rp[i].q[RB-2:0], 1'b1};
      end else begin
        st.r <= r;
        st.q <= {rp[i].q[RB-2:0], 1'b0};
      end
    end
    assign rp[i+1] = st;
  end

  // divider setup
  typedef struct packed {
    sd_t d;
    logic neg, zn, zd;
    logic [DW-1:0] n, den, r, q;
  } dv_t;
  dv_t dp [DS+1];
  always_comb begin
    logic [DW-1:0] den;
    logic          dneg;
    den  = DW'(rp[RS].q);
    dneg = 1'b0;
    if (rp[RS].d.b.mode == MODE_ADAGRAD) den = den + DW'(rp[RS].d.b.eps);
    dp[0].d   = rp[RS].d;
    dp[0].neg = rp[RS].d.num[XW-1] ^ dneg;
    dp[0].n   = DW'(rp[RS].d.num[XW-1] ? -rp[RS].d.num : rp[RS].d.num) << F;
    dp[0].den = den;
    dp[0].zn  = rp[RS].d.num == '0;
    dp[0].zd  = den == '0;
    dp[0].r   = '0;
    dp[0].q   = '0;
  end
  for (genvar i = 0; i < DS; i++) begin : g_div
    dv_t st;
    always_ff @(posedge clk) if (adv) begin
      dv_t           nx;
      logic [DW-1:0] r;
      nx   = dp[i];
      r    = {dp[i].r[DW-2:0], dp[i].n[DW-1]};
      nx.n = dp[i].n << 1;
      if (r >= dp[i].den) begin
        nx.r = r - dp[i].den;
        nx.q = {dp[i].q[DW-2:0], 1'b1};
      end else begin
        nx.r = r;
        nx.q = {dp[i].q[DW-2:0], 1'b0};
      end
      st <= nx;
    end
    assign dp[i+1] = st;
  end

  // final: quotient saturate and weight update
  typedef struct packed {
    logic signed [W-1:0] w, m;
    logic [W-2:0]        v;
    logic                last;
  } so_t;
  so_t so;
  always_ff @(posedge clk) if (adv) begin
    wx_t quo, nw;
    sd_t d;
    d = dp[DS].d;
    if (dp[DS].zn) quo = '0;
    else if (dp[DS].zd || dp[DS].q > DW'(WMAX)) quo = dp[DS].neg ? WMIN : WMAX;
    else quo = dp[DS].neg ? -XW'(dp[DS].q) : XW'(dp[DS].q);
    nw = d.b.w;
    unique case (d.b.mode)
      MODE_SGD:      nw = sat((2*XW+2)'(d.b.w) - (2*XW+2)'(d.num));
      MODE_MOMENTUM: nw = sat((2*XW+2)'(d.b.w) + (2*XW+2)'(d.nm));
      MODE_RMSPROP, MODE_ADAGRAD: nw = sat((2*XW+2)'(d.b.w) - (2*XW+2)'(quo));
      MODE_ADAM:     nw = sat((2*XW+2)'(d.b.w) + (2*XW+2)'(quo));
      default: ;
    endcase
    so.w    <= W'(nw);
    so.m    <= W'(d.nm);
    so.v    <= (W-1)'(d.nv);
    so.last <= d.b.last;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], in_valid};
  end

  assign out_valid    = vld[NS-1];
  assign weight_out   = so.w;
  assign moment_out   = so.m;
  assign sq_accum_out = so.v;
  assign last_out     = so.last;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(weight_out))
    else $error("output word lost under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_move: assert property (@(posedge clk) disable iff (rst)
    !out_stall |=> vld[NS-1] == $past(vld[NS-2]))
    else $error("valid bit did not advance");

endmodule

/* tb/tb.sv */
// Self-checking testbench for weight_update_optimizer: directed table then random words,
// every mode and several register settings, checked against a local Q8.24 update predictor.
// Depends on wuo_pkg and the weight_update_optimizer RTL.
`timescale 1ns / 100ps

module tb;
  import wuo_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint ONE  = 64'sd16777216;
  localparam int     LAT  = 2 * 32 + 3 * 24 + 20;
  localparam int     DOG  = 20000;

  typedef struct {
    logic [31:0] w;
    logic [31:0] m;
    logic [30:0] v;
    logic        last;
  } upd_t;

  typedef struct {
    logic [31:0] g;
    logic [31:0] w;
    logic [31:0] m;
    logic [30:0] v;
    logic        last;
    bit          fixed;
    upd_t        res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] grad = 0, weight_in = 0, moment_in = 0;
  logic [30:0] sq_accum_in = 0;
  logic last_in = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] weight_out, moment_out;
  logic [30:0] sq_accum_out;
  logic last_out;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_MODE;
  logic [CFG_BITS-1:0] cfg_data = 0;

  weight_update_optimizer DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [2:0]  r_mode;
  logic [24:0] r_alpha, r_lambda, r_mu1, r_mu2, r_eps;
  upd_t        pending[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          rx_left = 0;
  bit          rx_hold = 0;
  bit          rx_burst = 0;

  function automatic longint sat(longint x);
    return x > WMAX ? WMAX : (x < WMIN ? WMIN : x);
  endfunction

  function automatic longint sat_acc(longint x);
    return x < 0 ? 0 : (x > WMAX ? WMAX : x);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    logic [127:0] mg;
    p = 128'(signed'(a)) * 128'(signed'(b));
    mg = p < 0 ? -p : p;
    mg = mg >> 24;
    if (mg > 128'(WMAX) + 1) mg = 128'(WMAX) + 1;
    return p < 0 ? sat(-longint'(mg)) : sat(longint'(mg));
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic signed [127:0] q;
    if (n == 0) return 0;
    if (d == 0) return n < 0 ? WMIN : WMAX;
    q = (128'(signed'(n)) <<< 24) / 128'(signed'(d));
    if (q > 128'(WMAX)) return WMAX;
    if (q < 128'(signed'(WMIN))) return WMIN;
    return longint'(q);
  endfunction

  function automatic longint qroot(longint x);
    logic [127:0] s, r, b;
    s = 128'(x < 0 ? 0 : x) << 24;
    r = 0;
    for (int i = 30; i >= 0; i--) begin
      b = r | (128'(1) << i);
      if (b * b <= s) r = b;
    end
    return longint'(r);
  endfunction

  function automatic upd_t predict_update(logic [31:0] gi, logic [31:0] wi, logic [31:0] mi,
                                          logic [30:0] vi, logic li);
    longint g, w, m, v, al, la, m1, m2, ep, gd, nw, nm, nv;
    upd_t r;
    g = longint'(signed'(gi)); w = longint'(signed'(wi)); m = longint'(signed'(mi));
    v = longint'(vi);
    al = r_alpha; la = r_lambda; m1 = r_mu1; m2 = r_mu2; ep = r_eps;
    gd = sat(g + qmul(w, la));
    nw = w; nm = m; nv = v;
    case (r_mode)
      MODE_SGD: nw = sat(w - qmul(al, gd));
      MODE_MOMENTUM: begin
        nm = sat(qmul(m1, m) - qmul(al, gd));
        nw = sat(w + nm);
      end
      MODE_RMSPROP: begin
        nv = sat_acc(qmul(v, m2) + qmul(qmul(ONE - m2, g), g));
        nw = sat(w - qdiv(qmul(al, gd), qroot(nv + ep)));
      end
      MODE_ADAGRAD: begin
        nv = sat_acc(v + qmul(g, g));
        nw = sat(w - qdiv(qmul(al, gd), qroot(nv) + ep));
      end
      MODE_ADAM: begin
        nm = sat(qmul(m1, m) - qmul(qmul(ONE - m1, al), gd));
        nv = sat_acc(qmul(v, m2) + qmul(qmul(ONE - m2, g), g));
        nw = sat(w + qdiv(nm, qroot(nv + ep)));
      end
      default: ;
    endcase
    r.w = nw[31:0]; r.m = nm[31:0]; r.v = nv[30:0]; r.last = li;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [24:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_MODE:   r_mode = val[2:0];
      REG_ALPHA:  r_alpha = val;
      REG_LAMBDA: r_lambda = val;
      REG_MU1:    r_mu1 = val;
      REG_MU2:    r_mu2 = val;
      REG_EPS:    r_eps = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [2:0] md, logic [24:0] al, logic [24:0] la,
                         logic [24:0] m1, logic [24:0] m2, logic [24:0] ep);
    write_reg(REG_MODE, 25'(md)); write_reg(REG_ALPHA, al); write_reg(REG_LAMBDA, la);
    write_reg(REG_MU1, m1); write_reg(REG_MU2, m2); write_reg(REG_EPS, ep);
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] g, logic [31:0] w, logic [31:0] m,
                           logic [30:0] v, logic l, bit fixed, upd_t res);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; grad <= g; weight_in <= w; moment_in <= m; sq_accum_in <= v; last_in <= l;
    pending.push_back(fixed ? res : predict_update(g, w, m, v, l));
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
      3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_words(int n);
    for (int i = 0; i < n; i++)
      send_word(rnd_word(), rnd_word(), rnd_word(), 31'(rnd_word()),
                1'($urandom), 0, '{0, 0, 0, 0});
    in_valid <= 0;
  endtask

  // hold the receiver: random stalls, a few long ones, plus one long burst
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      out_stall <= rx_hold;
    end else if (rx_left > 0) begin
      rx_left   <= rx_left - 1;
      out_stall <= 1;
    end else if (rx_burst) begin
      if ($urandom_range(0, 199) == 0) begin
        rx_left   <= $urandom_range(10, 40);
        out_stall <= 1;
      end else out_stall <= ($urandom_range(0, 3) == 0);
    end else out_stall <= 0;
  end

  always @(posedge clk) begin
    upd_t e;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > DOG) begin
        $display("status: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected word: w=%h", weight_out);
        end else begin
          e = pending.pop_front();
          if (e.w !== weight_out || e.m !== moment_out || e.v !== sq_accum_out ||
              e.last !== last_out) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp w=%h m=%h v=%h l=%b got w=%h m=%h v=%h l=%b",
                       e.w, e.m, e.v, e.last, weight_out, moment_out, sq_accum_out, last_out);
          end
        end
      end
    end
  end

  row_t dir[$];

  initial begin
    r_mode = MODE_SGD; r_alpha = 167772; r_lambda = 0; r_mu1 = 15099494;
    r_mu2 = 16760439; r_eps = 1;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table: after reset, zero-gradient rows give their expected result directly
    dir.push_back('{0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}});
    dir.push_back('{0, 32'h0100_0000, 5, 7, 1, 1, '{32'h0100_0000, 5, 7, 1}});
    dir.push_back('{32'h7FFF_FFFF, 0, 0, 0, 0, 0, '{0, 0, 0, 0}});
    dir.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1, 0,
                    '{0, 0, 0, 0}});
    dir.push_back('{32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, '{0, 0, 0, 0}});
    foreach (dir[i]) send_word(dir[i].g, dir[i].w, dir[i].m, dir[i].v, dir[i].last,
                               dir[i].fixed, dir[i].res);
    in_valid <= 0;
    drain();

    for (int md = 0; md < 8; md++) begin
      set_all(3'(md), 25'h100_0000, 25'h10_0000, 15099494, 16760439, 1);
      send_word(32'h0100_0000, 32'h0080_0000, 32'hFF00_0000, 31'h0100_0000, 1, 0,
                '{0, 0, 0, 0});
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0,
                '{0, 0, 0, 0});
      in_valid <= 0;
      drain();
    end
    // zero divisor and registers above one
    set_all(MODE_ADAGRAD, 25'h100_0000, 0, 25'h1FF_FFFF, 25'h1FF_FFFF, 0);
    send_word(32'h0100_0000, 0, 0, 0, 0, 0, '{0, 0, 0, 0});
    send_word(0, 32'h0100_0000, 0, 0, 0, 0, '{0, 0, 0, 0});
    send_word(1, 0, 0, 0, 1, 0, '{0, 0, 0, 0});
    in_valid <= 0;
    drain();
    write_reg(REG_MODE, 25'(MODE_RMSPROP));
    send_word(32'hFF00_0000, 5, 3, 31'h4000_0000, 1, 0, '{0, 0, 0, 0});
    in_valid <= 0;
    drain();

    rx_burst = 1;
    for (int ph = 0; ph < 8; ph++) begin
      set_all(3'(ph < 5 ? ph : $urandom_range(0, 4)),
              25'(ph == 6 ? 0 : $urandom_range(0, 25'h100_0000)),
              25'(ph == 7 ? 25'h100_0000 : $urandom_range(0, 25'h4_0000)),
              25'(ph == 6 ? 25'h100_0000 : $urandom_range(25'hC0_0000, 25'h100_0000)),
              25'(ph == 7 ? 0 : $urandom_range(25'hF0_0000, 25'h100_0000)),
              25'(ph == 5 ? 25'h100_0000 : $urandom_range(1, 25'h1000)));
      if (ph == 3) begin
        fork
          begin rx_hold = 1; repeat (LAT + 300) @(posedge clk); rx_hold = 0; end
          random_words(80);
        join
      end else random_words(80);
      drain();
    end

    if (errors == 0 && pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
